### src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// Field widths, operation codes and the request and response beat layouts.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_BITS    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int USES_BITS   = 16;
   localparam int STAMP_BITS  = 32;
   localparam int CFG_BITS    = 5;
   localparam int DEF_ENTRIES = 16;

   localparam logic [USES_BITS-1:0] USES_MAX = '1;
   localparam logic [CFG_BITS-1:0]  CAPACITY_RESET = CFG_BITS'(16);

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                opcode;
      logic [KEY_BITS-1:0]   lookup_key;
      logic [VALUE_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } rsp_type;

endpackage

### src/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table: key/value table with LFU replacement and LRU tie-break
// Sequential scan of the entry memory, one entry per cycle, then one commit.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid, req_stall, req_data): one beat is a get or a
//   put. req_stall is high while an item is being worked on.
//   Response channel (rsp_valid, rsp_stall, rsp_data): one beat per request,
//   carrying the hit flag, the value read and any evicted key.
//   Configuration channel (csr_valid, csr_ready, csr_wdata): writes the
//   capacity limit; it is always ready and should only be used when idle.
// Timing
//   After a request beat the block reads one entry per cycle in ST_SCAN and
//   compares each entry in the cycle after its read, ends with the last
//   compare in ST_LAST and commits in ST_COMMIT, which registers the
//   response; the next request is taken only back in ST_IDLE. The single
//   memory read port sets this pace.
// Reset and stalls
//   Reset empties the table at once (valid bits are flip-flops), zeroes the
//   use stamp and sets the capacity to 16. A new request is accepted while a
//   response is still held; a stalled response holds the commit cycle until
//   the output register is free.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
   parameter int ENTRIES = lfu_pkg::DEF_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lfu_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lfu_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfu_pkg::CFG_BITS-1:0]    csr_wdata
);
   import lfu_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CFG_BITS) ? OCC_W : CFG_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
   localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LAST   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   // Entry memories.
   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [USES_BITS-1:0]  uses_mem  [ENTRIES];
   logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [ENTRIES-1:0]     valid_ff;
   logic [CFG_BITS-1:0]    cap_ff;
   logic [STAMP_BITS-1:0]  use_clock_ff;
   req_type                req_ff;

   logic                   cmp_vld_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic                   rd_valid_ff;
   logic [KEY_BITS-1:0]    rd_key_ff;
   logic [VALUE_BITS-1:0]  rd_value_ff;
   logic [USES_BITS-1:0]   rd_uses_ff;
   logic [STAMP_BITS-1:0]  rd_stamp_ff;

   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0]  hit_value_ff, hit_value_in;
   logic [USES_BITS-1:0]   hit_uses_ff, hit_uses_in;
   logic                   min_found_ff, min_found_in;
   logic [IDX_W-1:0]       min_idx_ff, min_idx_in;
   logic [USES_BITS-1:0]   min_uses_ff, min_uses_in;
   logic [STAMP_BITS-1:0]  min_stamp_ff, min_stamp_in;
   logic [KEY_BITS-1:0]    min_key_ff, min_key_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_go, out_free, commit_go;
   logic [CMP_W-1:0]       cap_eff, occ_ext;
   logic                   is_put, table_full, do_touch, do_install, do_evict, do_write;
   logic [IDX_W-1:0]       wr_idx;
   logic [USES_BITS-1:0]   uses_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_go    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit_go = (state_ff == ST_COMMIT) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Scan compare: one entry per cycle, following the registered memory read.
   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_value_in  = hit_value_ff;
      hit_uses_in   = hit_uses_ff;
      min_found_in  = min_found_ff;
      min_idx_in    = min_idx_ff;
      min_uses_in   = min_uses_ff;
      min_stamp_in  = min_stamp_ff;
      min_key_in    = min_key_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      occ_in        = occ_ff;
      if (req_go) begin
         hit_in        = 1'b0;
         min_found_in  = 1'b0;
         free_found_in = 1'b0;
         occ_in        = '0;
      end else if (cmp_vld_ff && rd_valid_ff) begin
         occ_in = occ_ff + 1'b1;
         if (!hit_ff && (rd_key_ff == req_ff.lookup_key)) begin
            hit_in       = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_value_in = rd_value_ff;
            hit_uses_in  = rd_uses_ff;
         end
         // A strict compare keeps the lowest index among identical entries.
         if (!min_found_ff || ({rd_uses_ff, rd_stamp_ff} < {min_uses_ff, min_stamp_ff})) begin
            min_found_in = 1'b1;
            min_idx_in   = cmp_idx_ff;
            min_uses_in  = rd_uses_ff;
            min_stamp_in = rd_stamp_ff;
            min_key_in   = rd_key_ff;
         end
      end else if (cmp_vld_ff && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_idx_ff;
      end
   end

   // Commit decisions.
   always_comb begin
      cap_eff    = (CMP_W'(cap_ff) > ENTRIES_C) ? ENTRIES_C : CMP_W'(cap_ff);
      occ_ext    = CMP_W'(occ_ff);
      is_put     = (req_ff.opcode == OP_PUT);
      table_full = (occ_ext >= cap_eff);
      do_touch   = hit_ff && (!is_put || (cap_eff != '0));
      do_install = is_put && (cap_eff != '0) && !hit_ff;
      do_evict   = do_install && table_full && min_found_ff;
      do_write   = do_touch || do_install;
      if (hit_ff) begin
         wr_idx = hit_idx_ff;
      end else if (table_full) begin
         wr_idx = min_idx_ff;
      end else begin
         wr_idx = free_idx_ff;
      end
      if (!hit_ff) begin
         uses_next = USES_BITS'(1);
      end else if (hit_uses_ff == USES_MAX) begin
         uses_next = hit_uses_ff;
      end else begin
         uses_next = hit_uses_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in.hit         = hit_ff;
      rsp_in.read_value  = (!is_put && hit_ff) ? hit_value_ff : '0;
      rsp_in.evicted     = do_evict;
      rsp_in.evicted_key = do_evict ? min_key_ff : '0;
      rsp_valid_in       = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         valid_ff      <= '0;
         cap_ff        <= CAPACITY_RESET;
         use_clock_ff  <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         min_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         occ_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_vld_ff    <= (state_ff == ST_SCAN);
         hit_ff        <= hit_in;
         min_found_ff  <= min_found_in;
         free_found_ff <= free_found_in;
         occ_ff        <= occ_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_wdata;
         end
         if (commit_go && do_install) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (commit_go && do_write) begin
            use_clock_ff <= use_clock_ff + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_go) begin
         req_ff <= req_data;
      end
      cmp_idx_ff   <= scan_idx_ff;
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      hit_uses_ff  <= hit_uses_in;
      min_idx_ff   <= min_idx_in;
      min_uses_ff  <= min_uses_in;
      min_stamp_ff <= min_stamp_in;
      min_key_ff   <= min_key_in;
      free_idx_ff  <= free_idx_in;
      if (commit_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // Entry memories: one read address and one write address per cycle.
   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[scan_idx_ff];
      rd_key_ff   <= key_mem[scan_idx_ff];
      rd_value_ff <= value_mem[scan_idx_ff];
      rd_uses_ff  <= uses_mem[scan_idx_ff];
      rd_stamp_ff <= stamp_mem[scan_idx_ff];
      if (commit_go && do_write) begin
         uses_mem[wr_idx]  <= uses_next;
         stamp_mem[wr_idx] <= use_clock_ff;
         if (is_put) begin
            value_mem[wr_idx] <= req_ff.write_value;
         end
         if (do_install) begin
            key_mem[wr_idx] <= req_ff.lookup_key;
         end
      end
   end

   // The table gains at most one entry per item.
   a_occupancy_step: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= $countones($past(valid_ff)) + 1)
      else $error("more than one entry became valid in one cycle");

   // An accepted request always starts a scan.
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_go |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("request accepted without starting a scan");

   // Compare beats only follow reads issued by the scan.
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN) || (state_ff == ST_LAST))
      else $error("compare beat outside the scan");

   // An install always has a victim or a free slot to go to.
   a_install_slot: assert property (@(posedge clock) disable iff (reset)
      commit_go && do_install |-> (table_full ? min_found_ff : free_found_ff))
      else $error("install without a target slot");

endmodule
